// ===== rtl/quad_to_rect_homography_defines.svh =====
// Assertion macros shared by the quad-to-rectangle mapping design.
`ifndef QUAD_TO_RECT_HOMOGRAPHY_DEFINES_SVH
`define QUAD_TO_RECT_HOMOGRAPHY_DEFINES_SVH
`ifndef ASSERT_OFF
`define Q2RH_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define Q2RH_ASSERT_NORST(name, clk, prop, msg) \
  name: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define Q2RH_ASSERT(name, clk, rst_n, prop, msg)
`define Q2RH_ASSERT_NORST(name, clk, prop, msg)
`endif
`endif

// ===== rtl/q2rh_pkg.sv =====
// Types, constants and saturating arithmetic helpers for the homography pipeline.
`timescale 1ns / 1ps
package q2rh_pkg;

  typedef logic signed [63:0] q_t;

  typedef struct packed {
    q_t   val;
    logic sat;
  } sval_t;

  localparam q_t Q_MAX = 64'sh7fff_ffff_ffff_ffff;
  localparam q_t Q_MIN = 64'sh8000_0000_0000_0000;
  localparam q_t Q_ONE = 64'sh0000_0001_0000_0000;

  localparam logic [1:0] ST_BAD    = 2'd0;
  localparam logic [1:0] ST_AFFINE = 2'd1;
  localparam logic [1:0] ST_PERSP  = 2'd2;

  localparam int unsigned MUL_LAT   = 5;
  localparam int unsigned DIV_STEPS = 64;
  localparam int unsigned DIV_LAT   = DIV_STEPS + 3;

  function automatic q_t q_of(input logic [31:0] v);
    return {{16{v[31]}}, v, 16'h0000};
  endfunction

  function automatic sval_t q_add(input q_t a, input q_t b);
    sval_t      r;
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    r.sat = (s[64] != s[63]);
    r.val = r.sat ? (s[64] ? Q_MIN : Q_MAX) : s[63:0];
    return r;
  endfunction

  function automatic sval_t q_sub(input q_t a, input q_t b);
    sval_t      r;
    logic [64:0] s;
    s = {a[63], a} - {b[63], b};
    r.sat = (s[64] != s[63]);
    r.val = r.sat ? (s[64] ? Q_MIN : Q_MAX) : s[63:0];
    return r;
  endfunction

  function automatic sval_t sat_mag(input logic neg, input logic big, input logic [63:0] m);
    sval_t r;
    if (big) begin
      r.sat = 1'b1;
      r.val = neg ? Q_MIN : Q_MAX;
    end else if (!neg) begin
      r.sat = m[63];
      r.val = m[63] ? Q_MAX : m;
    end else begin
      r.sat = m > 64'h8000_0000_0000_0000;
      r.val = r.sat ? Q_MIN : (64'd0 - m);
    end
    return r;
  endfunction

endpackage

// ===== rtl/q2rh_req_if.sv =====
// Request channel carrying the quadrilateral corners and rectangle bounds.
`timescale 1ns / 1ps
interface q2rh_req_if;
  logic              valid;
  logic              ready;
  logic signed [31:0] quad_x0;
  logic signed [31:0] quad_y0;
  logic signed [31:0] quad_x1;
  logic signed [31:0] quad_y1;
  logic signed [31:0] quad_x2;
  logic signed [31:0] quad_y2;
  logic signed [31:0] quad_x3;
  logic signed [31:0] quad_y3;
  logic signed [31:0] rect_u_low;
  logic signed [31:0] rect_v_low;
  logic signed [31:0] rect_u_high;
  logic signed [31:0] rect_v_high;

  modport source (
    output valid, quad_x0, quad_y0, quad_x1, quad_y1, quad_x2, quad_y2, quad_x3, quad_y3,
           rect_u_low, rect_v_low, rect_u_high, rect_v_high,
    input  ready
  );
  modport sink (
    input  valid, quad_x0, quad_y0, quad_x1, quad_y1, quad_x2, quad_y2, quad_x3, quad_y3,
           rect_u_low, rect_v_low, rect_u_high, rect_v_high,
    output ready
  );
endinterface

// ===== rtl/q2rh_rsp_if.sv =====
// Result channel carrying the quad-to-rectangle matrix and status.
`timescale 1ns / 1ps
interface q2rh_rsp_if;
  logic              valid;
  logic              ready;
  logic signed [63:0] m00;
  logic signed [63:0] m01;
  logic signed [63:0] m02;
  logic signed [63:0] m10;
  logic signed [63:0] m11;
  logic signed [63:0] m12;
  logic signed [63:0] m20;
  logic signed [63:0] m21;
  logic signed [63:0] m22;
  logic [1:0]        map_status;
  logic              singular_flag;
  logic              saturated_flag;

  modport source (
    output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
           map_status, singular_flag, saturated_flag,
    input  ready
  );
  modport sink (
    input  valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
           map_status, singular_flag, saturated_flag,
    output ready
  );
endinterface

// ===== rtl/quad_to_rect_homography.sv =====
// Top level of the pipelined quadrilateral-to-rectangle homography generator.
//
//   channel  direction  contents
//   req_i    in         four quad corners and rectangle bounds, Q16.16
//   rsp_o    out        adjugate matrix m00..m22 in Q32.32, status and flags
//
// One request is taken per cycle while the pipeline advances; the length up to the output
// register is set by two chained 67-stage dividers and five 5-stage multiplier banks. The
// whole pipeline advances together and holds only when its last stage is full and the
// output register is waiting. Reset clears the valid bits; no other setup is needed.
`timescale 1ns / 1ps
`include "quad_to_rect_homography_defines.svh"
module quad_to_rect_homography
  import q2rh_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  q2rh_req_if.sink      req_i,
  q2rh_rsp_if.source    rsp_o
);

  localparam int unsigned LM = MUL_LAT;
  localparam int unsigned LD = DIV_LAT;
  localparam int unsigned T1 = LM + 1 + LD;
  localparam int unsigned TS = T1 + LM + 1;
  localparam int unsigned T2 = TS + LD + LM + 1;
  localparam int unsigned TA = T2 + LM + 1;
  localparam int unsigned TF = TA + LM;

  logic adv;
  logic last_valid;

  // Entry stage.
  logic [3:0][63:0] x_c, y_c;
  logic [32:0]      dur, dvr;
  logic [3:0][63:0] x_a_q, y_a_q;
  logic [63:0]      px_a_q, py_a_q, dx1_a_q, dx2_a_q, dy1_a_q, dy2_a_q;
  logic [63:0]      du_a_q, dv_a_q, u0_a_q, v0_a_q;
  logic signed [32:0] e1_q, e2_q, e3_q, e4_q;
  logic             va_q, null_a_q, aff_a_q;

  assign x_c[0] = q_of(req_i.quad_x0);
  assign x_c[1] = q_of(req_i.quad_x1);
  assign x_c[2] = q_of(req_i.quad_x2);
  assign x_c[3] = q_of(req_i.quad_x3);
  assign y_c[0] = q_of(req_i.quad_y0);
  assign y_c[1] = q_of(req_i.quad_y1);
  assign y_c[2] = q_of(req_i.quad_y2);
  assign y_c[3] = q_of(req_i.quad_y3);
  assign dur = {req_i.rect_u_high[31], req_i.rect_u_high}
             - {req_i.rect_u_low[31], req_i.rect_u_low};
  assign dvr = {req_i.rect_v_high[31], req_i.rect_v_high}
             - {req_i.rect_v_low[31], req_i.rect_v_low};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q     <= 1'b0;
      null_a_q <= 1'b0;
      aff_a_q  <= 1'b0;
    end else if (adv) begin
      va_q     <= req_i.valid;
      null_a_q <= (dur == '0) || (dvr == '0);
      aff_a_q  <= (x_c[0] - x_c[1] + x_c[2] - x_c[3] == '0)
               && (y_c[0] - y_c[1] + y_c[2] - y_c[3] == '0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      x_a_q   <= x_c;
      y_a_q   <= y_c;
      px_a_q  <= x_c[0] - x_c[1] + x_c[2] - x_c[3];
      py_a_q  <= y_c[0] - y_c[1] + y_c[2] - y_c[3];
      dx1_a_q <= x_c[1] - x_c[2];
      dx2_a_q <= x_c[3] - x_c[2];
      dy1_a_q <= y_c[1] - y_c[2];
      dy2_a_q <= y_c[3] - y_c[2];
      du_a_q  <= {{15{dur[32]}}, dur, 16'h0000};
      dv_a_q  <= {{15{dvr[32]}}, dvr, 16'h0000};
      u0_a_q  <= q_of(req_i.rect_u_low);
      v0_a_q  <= q_of(req_i.rect_v_low);
      e1_q    <= {req_i.quad_x1[31], req_i.quad_x1} - {req_i.quad_x2[31], req_i.quad_x2};
      e2_q    <= {req_i.quad_y3[31], req_i.quad_y3} - {req_i.quad_y2[31], req_i.quad_y2};
      e3_q    <= {req_i.quad_x3[31], req_i.quad_x3} - {req_i.quad_x2[31], req_i.quad_x2};
      e4_q    <= {req_i.quad_y1[31], req_i.quad_y1} - {req_i.quad_y2[31], req_i.quad_y2};
    end
  end

  // Degenerate quad test on the raw corner differences.
  logic signed [65:0] pr1_q, pr2_q;
  logic               deg_c_q, deg_f;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pr1_q   <= e1_q * e2_q;
      pr2_q   <= e3_q * e4_q;
      deg_c_q <= (pr1_q == pr2_q);
    end
  end

  q2rh_dly #(.Width(1), .Depth(TF - 2)) u_dly_deg (
    .clk_i, .rst_ni, .en_i(adv), .d_i(deg_c_q), .q_o(deg_f)
  );

  logic va_f, null_f, aff_f;
  q2rh_dly #(.Width(3), .Depth(TF)) u_dly_ctrl (
    .clk_i, .rst_ni, .en_i(adv), .d_i({va_q, null_a_q, aff_a_q}), .q_o({va_f, null_f, aff_f})
  );

  // Cramer numerators and denominator.
  logic [5:0][63:0] m1_a, m1_b, m1_p;
  logic [5:0]       m1_s;

  assign m1_a[0] = dx1_a_q; assign m1_b[0] = dy2_a_q;
  assign m1_a[1] = dx2_a_q; assign m1_b[1] = dy1_a_q;
  assign m1_a[2] = px_a_q;  assign m1_b[2] = dy2_a_q;
  assign m1_a[3] = dx2_a_q; assign m1_b[3] = py_a_q;
  assign m1_a[4] = dx1_a_q; assign m1_b[4] = py_a_q;
  assign m1_a[5] = px_a_q;  assign m1_b[5] = dy1_a_q;

  for (genvar i = 0; i < 6; i++) begin : g_m1
    q2rh_mul u_mul (
      .clk_i, .en_i(adv), .a_i(m1_a[i]), .b_i(m1_b[i]), .p_o(m1_p[i]), .sat_o(m1_s[i])
    );
  end

  sval_t       del_c, n0_c, n1_c;
  logic [63:0] del_q, n0_q, n1_q;
  logic        s1_q;

  assign del_c = q_sub(m1_p[0], m1_p[1]);
  assign n0_c  = q_sub(m1_p[2], m1_p[3]);
  assign n1_c  = q_sub(m1_p[4], m1_p[5]);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      del_q <= del_c.val;
      n0_q  <= n0_c.val;
      n1_q  <= n1_c.val;
      s1_q  <= (|m1_s) | del_c.sat | n0_c.sat | n1_c.sat;
    end
  end

  logic [63:0] s02_t1, s12_t1;
  logic        ds0, ds1, s1_t1;

  q2rh_div u_div_s02 (
    .clk_i, .en_i(adv), .num_i(n0_q), .den_i(del_q), .quo_o(s02_t1), .sat_o(ds0)
  );
  q2rh_div u_div_s12 (
    .clk_i, .en_i(adv), .num_i(n1_q), .den_i(del_q), .quo_o(s12_t1), .sat_o(ds1)
  );
  q2rh_dly #(.Width(1), .Depth(LD)) u_dly_s1 (
    .clk_i, .rst_ni, .en_i(adv), .d_i(s1_q), .q_o(s1_t1)
  );

  // Corner coordinates travel alongside the perspective terms.
  logic [3:0][63:0] x_t1, y_t1, x_s, y_s;
  logic             aff_t1, aff_s;

  q2rh_dly #(.Width(513), .Depth(T1)) u_dly_xy1 (
    .clk_i, .rst_ni, .en_i(adv), .d_i({aff_a_q, x_a_q, y_a_q}), .q_o({aff_t1, x_t1, y_t1})
  );
  q2rh_dly #(.Width(513), .Depth(LM)) u_dly_xy2 (
    .clk_i, .rst_ni, .en_i(adv), .d_i({aff_t1, x_t1, y_t1}), .q_o({aff_s, x_s, y_s})
  );

  logic [3:0][63:0] m2_a, m2_b, m2_p;
  logic [3:0]       m2_s;

  assign m2_a[0] = s02_t1; assign m2_b[0] = x_t1[1];
  assign m2_a[1] = s12_t1; assign m2_b[1] = x_t1[3];
  assign m2_a[2] = s02_t1; assign m2_b[2] = y_t1[1];
  assign m2_a[3] = s12_t1; assign m2_b[3] = y_t1[3];

  for (genvar i = 0; i < 4; i++) begin : g_m2
    q2rh_mul u_mul (
      .clk_i, .en_i(adv), .a_i(m2_a[i]), .b_i(m2_b[i]), .p_o(m2_p[i]), .sat_o(m2_s[i])
    );
  end

  logic [63:0] s02_s, s12_s;
  logic        sat_t1_s;

  q2rh_dly #(.Width(129), .Depth(LM)) u_dly_c2 (
    .clk_i, .rst_ni, .en_i(adv), .d_i({s02_t1, s12_t1, s1_t1 | ds0 | ds1}),
    .q_o({s02_s, s12_s, sat_t1_s})
  );

  // Unit square to quad matrix.
  sval_t            a00, a10, a01, a11;
  logic [8:0][63:0] s_d, s_q;
  logic             sat_s_d, sat_s_q;

  assign a00 = q_add(x_s[1] - x_s[0], m2_p[0]);
  assign a10 = q_add(x_s[3] - x_s[0], m2_p[1]);
  assign a01 = q_add(y_s[1] - y_s[0], m2_p[2]);
  assign a11 = q_add(y_s[3] - y_s[0], m2_p[3]);

  always_comb begin
    s_d[6] = x_s[0];
    s_d[7] = y_s[0];
    s_d[8] = Q_ONE;
    if (aff_s) begin
      s_d[0]  = x_s[1] - x_s[0];
      s_d[1]  = y_s[1] - y_s[0];
      s_d[2]  = '0;
      s_d[3]  = x_s[2] - x_s[1];
      s_d[4]  = y_s[2] - y_s[1];
      s_d[5]  = '0;
      sat_s_d = 1'b0;
    end else begin
      s_d[0]  = a00.val;
      s_d[1]  = a01.val;
      s_d[2]  = s02_s;
      s_d[3]  = a10.val;
      s_d[4]  = a11.val;
      s_d[5]  = s12_s;
      sat_s_d = sat_t1_s | (|m2_s) | a00.sat | a10.sat | a01.sat | a11.sat;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s_q     <= s_d;
      sat_s_q <= sat_s_d;
    end
  end

  // Rescale to the rectangle.
  logic [63:0] du_s, dv_s, u0_s, v0_s, u0_m, v0_m;

  q2rh_dly #(.Width(256), .Depth(TS)) u_dly_uv1 (
    .clk_i, .rst_ni, .en_i(adv), .d_i({du_a_q, dv_a_q, u0_a_q, v0_a_q}),
    .q_o({du_s, dv_s, u0_s, v0_s})
  );
  q2rh_dly #(.Width(128), .Depth(LD)) u_dly_uv2 (
    .clk_i, .rst_ni, .en_i(adv), .d_i({u0_s, v0_s}), .q_o({u0_m, v0_m})
  );

  logic [5:0][63:0] r01, r01_r;
  logic [5:0]       d2_s;
  logic             sat_s_d2, sat_d2_r;

  for (genvar j = 0; j < 3; j++) begin : g_d2
    q2rh_div u_div_r0 (
      .clk_i, .en_i(adv), .num_i(s_q[j]), .den_i(du_s), .quo_o(r01[j]), .sat_o(d2_s[j])
    );
    q2rh_div u_div_r1 (
      .clk_i, .en_i(adv), .num_i(s_q[3+j]), .den_i(dv_s), .quo_o(r01[3+j]),
      .sat_o(d2_s[3+j])
    );
  end

  q2rh_dly #(.Width(1), .Depth(LD)) u_dly_sat_s (
    .clk_i, .rst_ni, .en_i(adv), .d_i(sat_s_q), .q_o(sat_s_d2)
  );
  q2rh_dly #(.Width(385), .Depth(LM)) u_dly_r01 (
    .clk_i, .rst_ni, .en_i(adv), .d_i({r01, sat_s_d2 | (|d2_s)}), .q_o({r01_r, sat_d2_r})
  );

  logic [5:0][63:0] m3_p;
  logic [5:0]       m3_s;

  for (genvar j = 0; j < 3; j++) begin : g_m3
    q2rh_mul u_mul_u (
      .clk_i, .en_i(adv), .a_i(r01[j]), .b_i(u0_m), .p_o(m3_p[j]), .sat_o(m3_s[j])
    );
    q2rh_mul u_mul_v (
      .clk_i, .en_i(adv), .a_i(r01[3+j]), .b_i(v0_m), .p_o(m3_p[3+j]), .sat_o(m3_s[3+j])
    );
  end

  logic [2:0][63:0] s2_r;

  q2rh_dly #(.Width(192), .Depth(LD + LM)) u_dly_s2 (
    .clk_i, .rst_ni, .en_i(adv), .d_i({s_q[6], s_q[7], s_q[8]}), .q_o(s2_r)
  );

  // Rectangle to quad matrix.
  logic [8:0][63:0] r_d, r_q;
  logic [2:0]       r2_sat;
  logic             sat_r_q;

  for (genvar j = 0; j < 3; j++) begin : g_r2
    sval_t sm, df;
    assign sm         = q_add(m3_p[j], m3_p[3+j]);
    assign df         = q_sub(s2_r[2-j], sm.val);
    assign r_d[j]     = r01_r[j];
    assign r_d[3+j]   = r01_r[3+j];
    assign r_d[6+j]   = df.val;
    assign r2_sat[j]  = sm.sat | df.sat;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      r_q     <= r_d;
      sat_r_q <= sat_d2_r | (|m3_s) | (|r2_sat);
    end
  end

  // Adjugate.
  logic [17:0][63:0] m4_p;
  logic [17:0]       m4_s;

  for (genvar i = 0; i < 3; i++) begin : g_ci
    for (genvar j = 0; j < 3; j++) begin : g_cj
      localparam int I1 = (i + 1) % 3;
      localparam int I2 = (i + 2) % 3;
      localparam int J1 = (j + 1) % 3;
      localparam int J2 = (j + 2) % 3;
      q2rh_mul u_mul_pa (
        .clk_i, .en_i(adv), .a_i(r_q[3*J1+I1]), .b_i(r_q[3*J2+I2]),
        .p_o(m4_p[2*(3*i+j)]), .sat_o(m4_s[2*(3*i+j)])
      );
      q2rh_mul u_mul_pb (
        .clk_i, .en_i(adv), .a_i(r_q[3*J1+I2]), .b_i(r_q[3*J2+I1]),
        .p_o(m4_p[2*(3*i+j)+1]), .sat_o(m4_s[2*(3*i+j)+1])
      );
    end
  end

  logic             sat_r_m4;
  logic [2:0][63:0] r0_a;

  q2rh_dly #(.Width(1), .Depth(LM)) u_dly_sat_r (
    .clk_i, .rst_ni, .en_i(adv), .d_i(sat_r_q), .q_o(sat_r_m4)
  );
  q2rh_dly #(.Width(192), .Depth(LM + 1)) u_dly_r0 (
    .clk_i, .rst_ni, .en_i(adv), .d_i({r_q[2], r_q[1], r_q[0]}), .q_o(r0_a)
  );

  logic [8:0][63:0] a_d, a_q, a_f;
  logic [8:0]       a_sat;
  logic             sat_a_q, sat_f;

  for (genvar k = 0; k < 9; k++) begin : g_adj
    sval_t cf;
    assign cf       = q_sub(m4_p[2*k], m4_p[2*k+1]);
    assign a_d[k]   = cf.val;
    assign a_sat[k] = cf.sat;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_q     <= a_d;
      sat_a_q <= sat_r_m4 | (|m4_s) | (|a_sat);
    end
  end

  // Determinant.
  logic [2:0][63:0] m5_p;

  for (genvar j = 0; j < 3; j++) begin : g_m5
    q2rh_mul u_mul (
      .clk_i, .en_i(adv), .a_i(r0_a[j]), .b_i(a_q[3*j]), .p_o(m5_p[j]), .sat_o()
    );
  end

  q2rh_dly #(.Width(577), .Depth(LM)) u_dly_a (
    .clk_i, .rst_ni, .en_i(adv), .d_i({a_q, sat_a_q}), .q_o({a_f, sat_f})
  );

  // Result register.
  sval_t            det1, det;
  logic             bad;
  logic [1:0]       status_d;
  logic [8:0][63:0] m_q;
  logic [1:0]       status_q;
  logic             sing_q, satf_q, out_valid_q;

  assign det1 = q_add(m5_p[0], m5_p[1]);
  assign det  = q_add(det1.val, m5_p[2]);
  assign bad  = null_f | (!aff_f & deg_f);

  always_comb begin
    if (bad) begin
      status_d = ST_BAD;
    end else if (aff_f) begin
      status_d = ST_AFFINE;
    end else begin
      status_d = ST_PERSP;
    end
  end

  assign last_valid = va_f;
  assign adv        = !last_valid || !out_valid_q || rsp_o.ready;
  assign req_i.ready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv && last_valid) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && last_valid) begin
      m_q      <= bad ? '0 : a_f;
      status_q <= status_d;
      sing_q   <= !bad && (det.val == '0);
      satf_q   <= !bad && sat_f;
    end
  end

  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.m00            = m_q[0];
  assign rsp_o.m01            = m_q[1];
  assign rsp_o.m02            = m_q[2];
  assign rsp_o.m10            = m_q[3];
  assign rsp_o.m11            = m_q[4];
  assign rsp_o.m12            = m_q[5];
  assign rsp_o.m20            = m_q[6];
  assign rsp_o.m21            = m_q[7];
  assign rsp_o.m22            = m_q[8];
  assign rsp_o.map_status     = status_q;
  assign rsp_o.singular_flag  = sing_q;
  assign rsp_o.saturated_flag = satf_q;

  `Q2RH_ASSERT(a_bad_zero, clk_i, rst_ni, (rsp_o.valid && rsp_o.map_status == ST_BAD) |-> (rsp_o.m00 == '0 && rsp_o.m11 == '0 && rsp_o.m22 == '0 && !rsp_o.singular_flag && !rsp_o.saturated_flag), "Bad mapping must give a zero matrix and clear flags.")
  `Q2RH_ASSERT(a_status_code, clk_i, rst_ni, rsp_o.valid |-> (rsp_o.map_status == ST_BAD || rsp_o.map_status == ST_AFFINE || rsp_o.map_status == ST_PERSP), "Result status is not a defined code.")
  `Q2RH_ASSERT(a_affine_col, clk_i, rst_ni, (rsp_o.valid && rsp_o.map_status == ST_AFFINE) |-> (rsp_o.m02 == '0 && rsp_o.m12 == '0), "Affine mapping must have a zero perspective column.")
  `Q2RH_ASSERT_NORST(a_stall_hold, clk_i, (last_valid && rsp_o.valid && !rsp_o.ready) |-> !req_i.ready, "Pipeline must not take a request while its last stage is blocked.")

endmodule

// ===== rtl/q2rh_mul.sv =====
// Pipelined saturating Q32.32 multiplier built from 32x32 partial products.
`timescale 1ns / 1ps
module q2rh_mul
  import q2rh_pkg::*;
(
  input  logic clk_i,
  input  logic en_i,
  input  q_t   a_i,
  input  q_t   b_i,
  output q_t   p_o,
  output logic sat_o
);

  logic        s1_neg_q, s2_neg_q, s3_neg_q, s4_neg_q;
  logic [63:0] s1_ma_q, s1_mb_q;
  logic [63:0] s2_p00_q, s2_p01_q, s2_p10_q, s2_p11_q;
  logic [64:0] s3_lo_q, s3_mid_q;
  logic [63:0] s3_p11_q;
  logic [127:0] s4_full_q;
  sval_t       s5_d, s5_q;

  assign s5_d = sat_mag(s4_neg_q, |s4_full_q[127:96], s4_full_q[95:32]);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_neg_q  <= a_i[63] ^ b_i[63];
      s1_ma_q   <= a_i[63] ? 64'd0 - a_i : a_i;
      s1_mb_q   <= b_i[63] ? 64'd0 - b_i : b_i;
      s2_neg_q  <= s1_neg_q;
      s2_p00_q  <= s1_ma_q[31:0] * s1_mb_q[31:0];
      s2_p01_q  <= s1_ma_q[31:0] * s1_mb_q[63:32];
      s2_p10_q  <= s1_ma_q[63:32] * s1_mb_q[31:0];
      s2_p11_q  <= s1_ma_q[63:32] * s1_mb_q[63:32];
      s3_neg_q  <= s2_neg_q;
      s3_lo_q   <= {1'b0, s2_p00_q} + 65'h0_8000_0000;
      s3_mid_q  <= {1'b0, s2_p01_q} + {1'b0, s2_p10_q};
      s3_p11_q  <= s2_p11_q;
      s4_neg_q  <= s3_neg_q;
      s4_full_q <= {s3_p11_q, 64'd0} + {31'd0, s3_mid_q, 32'd0} + {63'd0, s3_lo_q};
      s5_q      <= s5_d;
    end
  end

  assign p_o   = s5_q.val;
  assign sat_o = s5_q.sat;

endmodule

// ===== rtl/q2rh_div.sv =====
// Pipelined saturating Q32.32 divider, one quotient bit per stage with rounding.
`timescale 1ns / 1ps
module q2rh_div
  import q2rh_pkg::*;
(
  input  logic clk_i,
  input  logic en_i,
  input  q_t   num_i,
  input  q_t   den_i,
  output q_t   quo_o,
  output logic sat_o
);

  typedef struct packed {
    logic neg;
    logic dz;
    logic nz;
    logic nsign;
    logic ovf;
  } div_flag_t;

  logic [63:0] r_q [DIV_STEPS+1];
  logic [63:0] s_q [DIV_STEPS+1];
  logic [63:0] q_q [DIV_STEPS+1];
  logic [63:0] d_q [DIV_STEPS+1];
  div_flag_t   f_q [DIV_STEPS+1];

  logic [63:0] n_mag, d_mag;
  logic [63:0] fq_q;
  logic        rnd_q;
  div_flag_t   ff_q;
  logic [64:0] q1;
  sval_t       res_d, res_q;

  assign n_mag = num_i[63] ? 64'd0 - num_i : num_i;
  assign d_mag = den_i[63] ? 64'd0 - den_i : den_i;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q[0]       <= {32'd0, n_mag[63:32]};
      s_q[0]       <= {n_mag[31:0], 32'd0};
      q_q[0]       <= '0;
      d_q[0]       <= d_mag;
      f_q[0].neg   <= num_i[63] ^ den_i[63];
      f_q[0].dz    <= (den_i == '0);
      f_q[0].nz    <= (num_i == '0);
      f_q[0].nsign <= num_i[63];
      f_q[0].ovf   <= {32'd0, n_mag[63:32]} >= d_mag;
    end
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    logic [64:0] t;
    logic        ge;
    logic [64:0] diff;
    assign t    = {r_q[k], s_q[k][63]};
    assign ge   = t >= {1'b0, d_q[k]};
    assign diff = t - {1'b0, d_q[k]};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[k+1] <= ge ? diff[63:0] : t[63:0];
        s_q[k+1] <= {s_q[k][62:0], 1'b0};
        q_q[k+1] <= {q_q[k][62:0], ge};
        d_q[k+1] <= d_q[k];
        f_q[k+1] <= f_q[k];
      end
    end
  end

  assign q1 = {1'b0, fq_q} + {64'd0, rnd_q};

  always_comb begin
    if (ff_q.dz) begin
      res_d.sat = !ff_q.nz;
      res_d.val = ff_q.nz ? '0 : (ff_q.nsign ? Q_MIN : Q_MAX);
    end else begin
      res_d = sat_mag(ff_q.neg, ff_q.ovf | q1[64], q1[63:0]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      fq_q  <= q_q[DIV_STEPS];
      rnd_q <= r_q[DIV_STEPS] >= (d_q[DIV_STEPS] - r_q[DIV_STEPS]);
      ff_q  <= f_q[DIV_STEPS];
      res_q <= res_d;
    end
  end

  assign quo_o = res_q.val;
  assign sat_o = res_q.sat;

endmodule

// ===== rtl/q2rh_dly.sv =====
// Enabled delay line that keeps side data aligned with the arithmetic units.
`timescale 1ns / 1ps
module q2rh_dly #(
  parameter int unsigned Width = 1,
  parameter int unsigned Depth = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic [Width-1:0] d_i,
  output logic [Width-1:0] q_o
);

  logic [Width-1:0] pipe_q [Depth];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Depth; i++) pipe_q[i] <= '0;
    end else if (en_i) begin
      pipe_q[0] <= d_i;
      for (int i = 1; i < Depth; i++) pipe_q[i] <= pipe_q[i-1];
    end
  end

  assign q_o = pipe_q[Depth-1];

endmodule
